FILE: hw/rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared constants, codes and controller/datapath interface types for the
// LIFO slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsa_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned ALIGN_W   = 6;
  localparam int unsigned UNIT_W    = SIZE_W - ALIGN_W + 1;
  localparam int unsigned PROD_W    = IDX_W + UNIT_W;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = ADDR_W;

  localparam int unsigned IN_DATA_W  = ((IDX_W + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = IDX_W + ADDR_W + CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SLOTS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE_REQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR     = 2'd2;

  localparam logic [CNT_W-1:0]  RESET_NUM_SLOTS = CNT_W'(MAX_SLOTS);
  localparam logic [UNIT_W-1:0] RESET_UNITS     = UNIT_W'(1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_RANGE    = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    decide;
    logic    pop;
    logic    fresh;
    logic    push;
    status_t status;
    logic    compute;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic stack_empty;
    logic fresh_ok;
    logic in_range;
    logic list_full;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lsa_ctrl.sv
// ----------------------------------------------------------------------------
// lsa_ctrl
// Request sequencer: capture, decide pop/fresh/push, address multiply,
// result load.
// ----------------------------------------------------------------------------
`default_nettype none

module lsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire lsa_pkg::dp_status_t dp_status,
  input  wire logic              m_tready,
  output lsa_pkg::dp_cmd_t       dp_cmd
);
  import lsa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = ST_MUL;
      ST_MUL:    state_next = ST_FINISH;
      ST_FINISH: begin
        if (!dp_status.out_busy || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    dp_cmd   = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        dp_cmd.capture = s_tvalid;
      end
      ST_DECIDE: begin
        dp_cmd.decide = 1'b1;
        dp_cmd.status = STATUS_OK;
        if (!dp_status.is_free) begin
          priority if (!dp_status.stack_empty) begin
            dp_cmd.pop = 1'b1;
          end else if (dp_status.fresh_ok) begin
            dp_cmd.fresh = 1'b1;
          end else begin
            dp_cmd.status = STATUS_EMPTY;
          end
        end else begin
          priority if (!dp_status.in_range) begin
            dp_cmd.status = STATUS_RANGE;
          end else if (dp_status.list_full) begin
            dp_cmd.status = STATUS_OVERFLOW;
          end else begin
            dp_cmd.push = 1'b1;
          end
        end
      end
      ST_MUL: begin
        dp_cmd.compute = 1'b1;
      end
      ST_FINISH: begin
        dp_cmd.load_out = !dp_status.out_busy || m_tready;
      end
      default: begin
        dp_cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lsa_datapath.sv
// ----------------------------------------------------------------------------
// lsa_datapath
// Configuration registers, free stack memory, fresh index counter, address
// multiply/add and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsa_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lsa_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                               req_mode_in,
  input  wire logic [lsa_pkg::IDX_W-1:0]          req_index_in,
  input  wire lsa_pkg::dp_cmd_t                   dp_cmd,
  output lsa_pkg::dp_status_t                     dp_status,
  input  wire logic                               m_tready,
  output logic                                    out_valid,
  output lsa_pkg::status_t                        out_status,
  output logic [lsa_pkg::IDX_W-1:0]               out_index,
  output logic [lsa_pkg::ADDR_W-1:0]              out_addr,
  output logic [lsa_pkg::CNT_W-1:0]               out_avail
);
  import lsa_pkg::*;

  logic [CNT_W-1:0]  num_slots;
  logic [UNIT_W-1:0] size_units;
  logic [ADDR_W-1:0] base_addr;

  logic [CNT_W-1:0]  fresh_next;
  logic [CNT_W-1:0]  depth;
  logic [IDX_W-1:0]  mem [MAX_SLOTS];
  logic [IDX_W-1:0]  rd_data;

  logic              req_mode;
  logic [IDX_W-1:0]  req_index;
  logic              pop_sel;
  logic              got;
  status_t           status_reg;
  logic [IDX_W-1:0]  idx_reg;
  logic [IDX_W-1:0]  idx_fin;
  logic [PROD_W-1:0] product;

  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  untouched;
  logic [CNT_W:0]    avail_sum;
  logic [CNT_W-1:0]  depth_m1;
  logic [IDX_W-1:0]  idx_mux;
  logic [SIZE_W:0]   size_round;

  assign cnt_eff   = (num_slots > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : num_slots;
  assign untouched = (cnt_eff > fresh_next) ? (cnt_eff - fresh_next) : '0;
  assign avail_sum = {1'b0, untouched} + {1'b0, depth};
  assign depth_m1  = depth - CNT_W'(1);
  assign idx_mux   = pop_sel ? rd_data : idx_reg;
  assign size_round = {1'b0, cfg_wdata[SIZE_W-1:0]} + (SIZE_W+1)'((1 << ALIGN_W) - 1);

  always_comb begin
    dp_status.is_free     = req_mode;
    dp_status.stack_empty = (depth == '0);
    dp_status.fresh_ok    = (fresh_next < cnt_eff);
    dp_status.in_range    = ({1'b0, req_index} < cnt_eff);
    dp_status.list_full   = (avail_sum >= {1'b0, cnt_eff}) || (depth >= CNT_W'(MAX_SLOTS));
    dp_status.out_busy    = out_valid;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_slots  <= RESET_NUM_SLOTS;
      size_units <= RESET_UNITS;
      base_addr  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_SLOTS:     num_slots  <= cfg_wdata[CNT_W-1:0];
        REG_SLOT_SIZE_REQ: size_units <= size_round[SIZE_W:ALIGN_W];
        REG_BASE_ADDR:     base_addr  <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // allocation state
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_next <= '0;
      depth      <= '0;
    end else begin
      if (dp_cmd.fresh) begin
        fresh_next <= fresh_next + CNT_W'(1);
      end
      if (dp_cmd.push) begin
        depth <= depth + CNT_W'(1);
      end else if (dp_cmd.pop) begin
        depth <= depth_m1;
      end
    end
  end

  // free stack
  always_ff @(posedge clk) begin
    if (dp_cmd.push) begin
      mem[depth[IDX_W-1:0]] <= req_index;
    end
    if (dp_cmd.pop) begin
      rd_data <= mem[depth_m1[IDX_W-1:0]];
    end
  end

  // request, decision and address pipeline
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      req_mode  <= req_mode_in;
      req_index <= req_index_in;
    end
    if (dp_cmd.decide) begin
      status_reg <= dp_cmd.status;
      got        <= dp_cmd.pop || dp_cmd.fresh;
      pop_sel    <= dp_cmd.pop;
      idx_reg    <= fresh_next[IDX_W-1:0];
    end
    if (dp_cmd.compute) begin
      idx_fin <= idx_mux;
      product <= PROD_W'(idx_mux * size_units);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_out) begin
      out_status <= status_reg;
      out_index  <= got ? idx_fin : '0;
      out_addr   <= got ? (base_addr + ADDR_W'({product, {ALIGN_W{1'b0}}})) : '0;
      out_avail  <= avail_sum[CNT_W-1:0];
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CNT_W'(MAX_SLOTS))
    else $error("free stack depth beyond capacity");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= CNT_W'(MAX_SLOTS))
    else $error("fresh index counter beyond capacity");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.push |-> (depth < CNT_W'(MAX_SLOTS)) && !dp_cmd.pop)
    else $error("push with no room or together with pop");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.pop |-> (depth != '0))
    else $error("pop from empty stack");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load_out |-> (!out_valid || m_tready))
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

FILE: hw/rtl/lifo_slot_allocator.sv
// ----------------------------------------------------------------------------
// lifo_slot_allocator
// Fixed-slot allocator with a LIFO free list and slot address generation.
//
// Input stream: s_tuser is the request kind (0 allocate, 1 free), s_tdata
// carries the index to free. Each request yields exactly one output
// transaction: m_tuser is the status (ok, no slot free, index out of range,
// free list overflow), m_tdata the allocated index, its byte address and the
// free slot count after the request.
// Allocation takes a previously freed index, most recent first, otherwise the
// lowest never-used index. Address = base + index * roundup64(size).
// The sequencer captures a request, then steps decide (stack pop/push),
// multiply and add/load; it takes no new request until these steps are done.
// The result register decouples the output: a new request is taken while the
// previous result waits; a stalled receiver holds the block only when the next
// result is ready to load.
// Reset (synchronous): no slots handed out, free stack empty, registers at
// 1024 slots, slot size 64, base 0. Configure only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_slot_allocator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [lsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lsa_pkg::CFG_W-1:0]           cfg_wdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [lsa_pkg::IN_DATA_W-1:0]       s_tdata,   // free_index
  input  wire logic                                s_tuser,   // mode
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [lsa_pkg::OUT_DATA_W-1:0]           m_tdata,   // index, address, free count
  output logic [1:0]                               m_tuser    // status
);
  import lsa_pkg::*;

  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;
  status_t           out_status;
  logic [IDX_W-1:0]  out_index;
  logic [ADDR_W-1:0] out_addr;
  logic [CNT_W-1:0]  out_avail;

  lsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .dp_status (dp_status),
    .m_tready  (m_tready),
    .dp_cmd    (dp_cmd)
  );

  lsa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .req_mode_in  (s_tuser),
    .req_index_in (s_tdata[IDX_W-1:0]),
    .dp_cmd       (dp_cmd),
    .dp_status    (dp_status),
    .m_tready     (m_tready),
    .out_valid    (m_tvalid),
    .out_status   (out_status),
    .out_index    (out_index),
    .out_addr     (out_addr),
    .out_avail    (out_avail)
  );

  assign m_tuser = out_status;
  assign m_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_avail, out_addr, out_index};

endmodule

`default_nettype wire
